@@ rtl/awb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// awb_pkg
// Types and constants shared by the affine warp bilinear sampler.
// ----------------------------------------------------------------------------
package awb_pkg;

  localparam int DEF_MAX_SRC_WIDTH  = 256;
  localparam int DEF_MAX_SRC_HEIGHT = 256;
  localparam int NUM_CHANNELS       = 3;
  localparam int PIXEL_W            = 8 * NUM_CHANNELS;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  localparam logic [2:0] REG_STEP_A     = 3'd0;
  localparam logic [2:0] REG_STEP_B     = 3'd1;
  localparam logic [2:0] REG_ORIGIN_ROW = 3'd2;
  localparam logic [2:0] REG_ORIGIN_COL = 3'd3;
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd5;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       outside;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/awb_bank_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// awb_bank_ram
// One pixel bank: one write port, one registered read port.
// ----------------------------------------------------------------------------
module awb_bank_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 24
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data while the pipeline stalls
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/affine_warp_bilinear_sampler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// affine_warp_bilinear_sampler
// Loads an RGB source image and samples it through an affine map with
// bilinear interpolation.
// ----------------------------------------------------------------------------
//  channel  direction  payload     handshake
//  in_      input      in_item_t   in_valid / in_stall
//  out_     output     out_item_t  out_valid / out_stall
//  cfg_     input      32b wdata   cfg_wr_en, cfg_index (no read-back)
//
// One beat is taken per cycle while in_stall is low; sample results leave
// in order after the vertical blend stage. The rate is set by the four
// parity banks: the four neighbors of a point always sit in four different
// banks, so each bank serves one read per cycle. Reset clears control and
// configuration only; the pixel store is undefined until loaded. A stalled
// output beat freezes the whole pipeline and raises in_stall.
// ----------------------------------------------------------------------------
module affine_warp_bilinear_sampler #(
  parameter int MAX_SRC_WIDTH  = awb_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = awb_pkg::DEF_MAX_SRC_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire awb_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output awb_pkg::out_item_t     out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata
);

  import awb_pkg::*;

  // bank geometry: row parity x column parity
  localparam int BANK_H     = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BANK_W     = (MAX_SRC_WIDTH + 1) / 2;
  localparam int BANK_DEPTH = BANK_H * BANK_W;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CRW        = $clog2(MAX_SRC_HEIGHT) + 1;
  localparam int CCW        = $clog2(MAX_SRC_WIDTH) + 1;

  // ---------------- configuration registers ----------------
  logic signed [31:0] step_a_r, step_b_r, origin_row_r, origin_col_r;
  logic [8:0]         src_width_r, src_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_a_r     <= 32'sd65536;
      step_b_r     <= '0;
      origin_row_r <= '0;
      origin_col_r <= '0;
      src_width_r  <= 9'd256;
      src_height_r <= 9'd256;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_STEP_A:     step_a_r     <= cfg_wdata;
        REG_STEP_B:     step_b_r     <= cfg_wdata;
        REG_ORIGIN_ROW: origin_row_r <= cfg_wdata;
        REG_ORIGIN_COL: origin_col_r <= cfg_wdata;
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata[8:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together unless the output beat is held
  logic adv;
  logic out_valid_r;
  assign in_stall = out_valid_r & out_stall;
  assign adv      = ~in_stall;

  // ---------------- stage 1: products ----------------
  logic                v1_r;
  in_item_t            it1_r;
  logic signed [40:0]  ar_r, bc_r, br_r, ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r <= in_data;
      ar_r  <= step_a_r * $signed({1'b0, in_data.row});
      bc_r  <= step_b_r * $signed({1'b0, in_data.col});
      br_r  <= step_b_r * $signed({1'b0, in_data.row});
      ac_r  <= step_a_r * $signed({1'b0, in_data.col});
    end
  end

  // ---------------- stage 2: source coordinates ----------------
  logic               v2_r;
  in_item_t           it2_r;
  logic signed [41:0] sr_r, sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it2_r <= it1_r;
      sr_r  <= 42'(origin_row_r) + 42'(ar_r) + 42'(bc_r);
      sc_r  <= 42'(origin_col_r) - 42'(br_r) + 42'(ac_r);
    end
  end

  // ---------------- stage 3: bounds, bank access ----------------
  logic signed [25:0] ir, ic;
  logic signed [31:0] ir_w, ic_w, h_use, w_use;
  logic               in_square;
  logic [CRW-1:0]     ir_lo;
  logic [CCW-1:0]     ic_lo;
  logic               load_ok;

  always_comb begin
    ir    = sr_r[41:16];
    ic    = sc_r[41:16];
    ir_w  = {{6{ir[25]}}, ir};
    ic_w  = {{6{ic[25]}}, ic};
    h_use = (32'(src_height_r) < 32'(MAX_SRC_HEIGHT)) ? 32'(src_height_r)
                                                      : 32'(MAX_SRC_HEIGHT);
    w_use = (32'(src_width_r) < 32'(MAX_SRC_WIDTH)) ? 32'(src_width_r)
                                                    : 32'(MAX_SRC_WIDTH);
    in_square = !ir[25] && !ic[25] && (ir_w < h_use - 32'sd1) && (ic_w < w_use - 32'sd1);
    ir_lo  = ir[CRW-1:0];
    ic_lo  = ic[CCW-1:0];
    load_ok = (32'(it2_r.row) < 32'(MAX_SRC_HEIGHT)) &&
              (32'(it2_r.col) < 32'(MAX_SRC_WIDTH));
  end

  logic                we_any;
  logic [AW-1:0]       waddr;
  logic [PIXEL_W-1:0]  wpix;
  logic [PIXEL_W-1:0]  rdata [4];

  assign we_any = adv && v2_r && (it2_r.op == OP_LOAD) && load_ok;
  assign waddr  = AW'(32'(it2_r.row[7:1]) * BANK_W + 32'(it2_r.col[7:1]));
  assign wpix   = {it2_r.red_in, it2_r.green_in, it2_r.blue_in};

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam logic PR = 1'(k >> 1);
    localparam logic PC = 1'(k & 1);
    logic [CRW-1:0] rr;
    logic [CCW-1:0] cc;
    logic [AW-1:0]  raddr;
    logic           we_k;

    always_comb begin
      rr    = (ir_lo[0] == PR) ? ir_lo : ir_lo + CRW'(1);
      cc    = (ic_lo[0] == PC) ? ic_lo : ic_lo + CCW'(1);
      raddr = AW'(32'(rr >> 1) * BANK_W + 32'(cc >> 1));
      we_k  = we_any && (it2_r.row[0] == PR) && (it2_r.col[0] == PC);
    end

    awb_bank_ram #(
      .DEPTH (BANK_DEPTH),
      .AW    (AW),
      .DW    (PIXEL_W)
    ) u_bank (
      .clk   (clk),
      .we    (we_k),
      .waddr (waddr),
      .wdata (wpix),
      .re    (adv),
      .raddr (raddr),
      .rdata (rdata[k])
    );
  end

  logic        v3_r, out3_r, r0_r, c0_r;
  logic [15:0] fr3_r, fc3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      // drop loads here; only samples make results
      v3_r <= v2_r && (it2_r.op == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out3_r <= !in_square;
      r0_r   <= ir_lo[0];
      c0_r   <= ic_lo[0];
      fr3_r  <= sr_r[15:0];
      fc3_r  <= sc_r[15:0];
    end
  end

  // ---------------- stage 4: horizontal blend ----------------
  logic [PIXEL_W-1:0] p00, p01, p10, p11;
  logic [16:0]        fc_inv;
  logic [8:0]         top [NUM_CHANNELS];
  logic [8:0]         bot [NUM_CHANNELS];

  always_comb begin
    p00    = rdata[{r0_r, c0_r}];
    p01    = rdata[{r0_r, ~c0_r}];
    p10    = rdata[{~r0_r, c0_r}];
    p11    = rdata[{~r0_r, ~c0_r}];
    fc_inv = ONE_Q16 - {1'b0, fc3_r};
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      top[ch] = 9'((25'(fc_inv) * 25'(p00[PIXEL_W-1-8*ch -: 8])) >> 16)
              + 9'((25'(fc3_r) * 25'(p01[PIXEL_W-1-8*ch -: 8])) >> 16);
      bot[ch] = 9'((25'(fc_inv) * 25'(p10[PIXEL_W-1-8*ch -: 8])) >> 16)
              + 9'((25'(fc3_r) * 25'(p11[PIXEL_W-1-8*ch -: 8])) >> 16);
    end
  end

  logic        v4_r, out4_r;
  logic [15:0] fr4_r;
  logic [8:0]  top_r [NUM_CHANNELS];
  logic [8:0]  bot_r [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out4_r <= out3_r;
      fr4_r  <= fr3_r;
      top_r  <= top;
      bot_r  <= bot;
    end
  end

  // ---------------- stage 5: vertical blend into output register ----------------
  logic [16:0] fr_inv;
  logic [9:0]  vsum [NUM_CHANNELS];
  out_item_t   res_nxt, out_r;

  always_comb begin
    fr_inv = ONE_Q16 - {1'b0, fr4_r};
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      vsum[ch] = 10'((26'(fr_inv) * 26'(top_r[ch])) >> 16)
               + 10'((26'(fr4_r) * 26'(bot_r[ch])) >> 16);
    end
    res_nxt.red_out   = out4_r ? 8'd0 : vsum[0][7:0];
    res_nxt.green_out = out4_r ? 8'd0 : vsum[1][7:0];
    res_nxt.blue_out  = out4_r ? 8'd0 : vsum[2][7:0];
    res_nxt.outside   = out4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- checks ----------------
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.outside |->
      (out_r.red_out == 8'd0) && (out_r.green_out == 8'd0) && (out_r.blue_out == 8'd0))
    else $error("outside result carries nonzero channels");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v2_r) && $stable(v3_r) && $stable(v4_r))
    else $error("pipeline moved while output stalled");

  a_no_write_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !we_any)
    else $error("bank write during stall");

endmodule
`default_nettype wire
